FILE: sv/pmsc_pkg.sv
// Package for the PCM mixer with soft clip: widths, saturation limits,
// the soft-clip segment table and the structs passed between the sub-blocks.
// No dependencies.
package pmsc_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int ACC_W             = 22;
    localparam int LOW_W             = 15;
    localparam int SEG_COUNT         = 5;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [2:0] SEG_LAST = 3'(SEG_COUNT - 1);

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic push;
        t_acc sum;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_acc sum;
    } t_q_rd;

    function automatic logic [3:0] seg_shift(input logic [2:0] seg);
        logic [3:0] s;
        unique case (seg)
            3'd0:    s = 4'd3;
            3'd1:    s = 4'd6;
            3'd2:    s = 4'd9;
            3'd3:    s = 4'd12;
            default: s = 4'd15;
        endcase
        return s;
    endfunction

    function automatic logic [LOW_W-1:0] seg_offset(input logic [2:0] seg);
        logic [LOW_W-1:0] o;
        unique case (seg)
            3'd0:    o = 15'd0;
            3'd1:    o = 15'd28672;
            3'd2:    o = 15'd32256;
            3'd3:    o = 15'd32704;
            default: o = 15'd32760;
        endcase
        return o;
    endfunction

endpackage

FILE: sv/pmsc_front.sv
// Front end of the PCM mixer: accepts source samples and adds them into a
// saturating accumulator; the last source of a group is handed to the queue.
// Depends on pmsc_pkg.
module pmsc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [pmsc_pkg::SAMPLE_W-1:0] i_source_sample,
    input  logic                                i_last_source,
    input  logic                                i_q_full,
    output pmsc_pkg::t_q_wr                     o_q_wr
);
    import pmsc_pkg::*;

    t_acc                r_acc;
    t_acc                n_acc;
    logic signed [ACC_W:0] w_sum;
    t_acc                w_sat;
    logic                w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_sum    = {r_acc[ACC_W-1], r_acc}
                    + {{(ACC_W+1-SAMPLE_W){i_source_sample[SAMPLE_W-1]}}, i_source_sample};

    always_comb begin
        priority if (w_sum > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) begin
            w_sat = ACC_MAX;
        end else if (w_sum < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) begin
            w_sat = ACC_MIN;
        end else begin
            w_sat = w_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (w_accept) begin
            n_acc = i_last_source ? '0 : w_sat;
        end
    end

    assign o_q_wr.push = w_accept && i_last_source;
    assign o_q_wr.sum  = w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

FILE: sv/pmsc_queue.sv
// Short queue of finished sums between the accumulator and the soft-clip stage.
// Depends on pmsc_pkg.
module pmsc_queue #(
    parameter int QUEUE_DEPTH = pmsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmsc_pkg::t_q_wr i_q_wr,
    output logic            o_full,
    output pmsc_pkg::t_q_rd o_q_rd,
    input  logic            i_pop
);
    import pmsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_acc             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] r_tail;
    logic [PTR_W-1:0] n_tail;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full       = (r_count == CNT_FULL);
    assign o_q_rd.valid = (r_count != '0);
    assign o_q_rd.sum   = r_mem[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_q_wr.push) begin
            n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
        end
        if (i_pop) begin
            n_head = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
        end
        unique case ({i_q_wr.push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_q_wr.push) begin
            r_mem[r_tail] <= i_q_wr.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("Queue count exceeds its depth.");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("Queue popped while empty.");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_wr.push |-> r_count != CNT_FULL)
        else $error("Queue written while full.");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_wr.push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("Queue count did not follow a write.");
`endif

endmodule

FILE: sv/pmsc_back.sv
// Back end of the PCM mixer: takes a finished sum from the queue, applies the
// five-segment soft clip and holds the result in the output register.
// Depends on pmsc_pkg.
module pmsc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pmsc_pkg::t_q_rd                      i_q_rd,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pmsc_pkg::SAMPLE_W-1:0] o_mixed_sample
);
    import pmsc_pkg::*;

    logic                        r_valid;
    logic                        n_valid;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic                        w_neg;
    logic [ACC_W-1:0]            w_mag;
    logic [ACC_W-LOW_W-1:0]      w_seg_raw;
    logic [2:0]                  w_seg;
    logic [LOW_W-1:0]            w_low;
    logic [LOW_W+2:0]            w_prod;
    logic [LOW_W+2:0]            w_shifted;
    logic [LOW_W-1:0]            w_mag_out;
    logic signed [SAMPLE_W-1:0]  w_clip;

    assign w_neg     = i_q_rd.sum[ACC_W-1];
    assign w_mag     = w_neg ? ACC_W'(-i_q_rd.sum) : ACC_W'(i_q_rd.sum);
    assign w_seg_raw = w_mag[ACC_W-1:LOW_W];
    assign w_seg     = (w_seg_raw > (ACC_W-LOW_W)'(SEG_LAST)) ? SEG_LAST : w_seg_raw[2:0];
    assign w_low     = w_mag[LOW_W-1:0];
    assign w_prod    = {w_low, 3'b000} - {3'b000, w_low};
    assign w_shifted = w_prod >> seg_shift(w_seg);
    assign w_mag_out = w_shifted[LOW_W-1:0] + seg_offset(w_seg);
    assign w_clip    = w_neg ? -$signed({1'b0, w_mag_out}) : $signed({1'b0, w_mag_out});

    assign o_pop   = i_q_rd.valid && (!r_valid || i_ready);
    assign n_valid = o_pop ? 1'b1 : (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid        = r_valid;
    assign o_mixed_sample = r_sample;

`ifndef SYNTH
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("Output register not valid after a load.");
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_valid || i_ready))
        else $error("Result loaded over one not yet taken.");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_sample <= 16'sd32766 && r_sample >= -16'sd32766))
        else $error("Mixed sample outside the soft-clip range.");
`endif

endmodule

FILE: sv/pcm_mixer_soft_clip_unit.sv
// PCM mixer with soft clip. One source sample is taken per request; the
// request flagged as the last source closes the group and yields one mixed,
// soft-clipped sample. The input channel (i_valid/o_ready) and the output
// channel (o_valid/i_ready) use valid/ready handshakes.
// The sum of an accepted last-source request is written into the queue and
// then loaded into the output register. Throughput, while the queue is not
// full: one request per cycle, sustained; a group can close every cycle.
// The accumulator saturates at the 22-bit signed limits and clears after
// each group. Finished sums wait in a short queue (QUEUE_DEPTH entries) in
// front of the soft-clip stage, whose output register holds the result.
// When the receiver stalls, the output register holds its sample, the queue
// fills, and o_ready falls only once the queue is full.
// Reset (i_rst_n low at a clock edge) clears the accumulator, empties the
// queue and drops o_valid; no clearing pass is needed.
// Depends on pmsc_pkg, pmsc_front, pmsc_queue and pmsc_back.
module pcm_mixer_soft_clip_unit #(
    parameter int QUEUE_DEPTH = pmsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [pmsc_pkg::SAMPLE_W-1:0] i_source_sample,
    input  logic                                 i_last_source,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pmsc_pkg::SAMPLE_W-1:0] o_mixed_sample
);
    import pmsc_pkg::*;

    t_q_wr w_q_wr;
    t_q_rd w_q_rd;
    logic  w_q_full;
    logic  w_pop;

    pmsc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_source_sample (i_source_sample),
        .i_last_source   (i_last_source),
        .i_q_full        (w_q_full),
        .o_q_wr          (w_q_wr)
    );

    pmsc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (w_q_wr),
        .o_full  (w_q_full),
        .o_q_rd  (w_q_rd),
        .i_pop   (w_pop)
    );

    pmsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_rd         (w_q_rd),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mixed_sample (o_mixed_sample)
    );

endmodule
